// File: sv/inventory_skewed_quote_pricer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quote pricer
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef INVENTORY_SKEWED_QUOTE_PRICER_CORE_DEFINES_SVH
`define INVENTORY_SKEWED_QUOTE_PRICER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IQP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IQP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IQP_ASSERT(lbl, prop, msg)
`define IQP_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: sv/iqp_pkg.sv
// ----------------------------------------------------------------------------
// iqp_pkg
// Shared types and codes of the quote pricer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package iqp_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_TRADE  = 2'd1;
  localparam logic [1:0] OP_DECIDE = 2'd2;

  localparam logic [1:0] REF_CONFIG = 2'd0;
  localparam logic [1:0] REF_TRADE  = 2'd1;

  localparam logic [2:0] REG_REF_SRC  = 3'd0;
  localparam logic [2:0] REG_CFG_REF  = 3'd1;
  localparam logic [2:0] REG_GRID_MIN = 3'd2;
  localparam logic [2:0] REG_GRID_INC = 3'd3;
  localparam logic [2:0] REG_BID_OFF  = 3'd4;
  localparam logic [2:0] REG_ASK_OFF  = 3'd5;
  localparam logic [2:0] REG_MAX_SKEW = 3'd6;
  localparam logic [2:0] REG_POS_LIM  = 3'd7;

  localparam int DIV_W = 40;
  localparam int DVS_W = 32;

  typedef enum logic [1:0] {
    K_UPDATE,
    K_TRADE,
    K_DECIDE,
    K_KILL
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_UW,
    S_SCAN,
    S_REF,
    S_MID,
    S_CDIV,
    S_CW,
    S_SKEW,
    S_SDIV,
    S_SW,
    S_ADJ,
    S_OFF,
    S_LIM,
    S_PRC,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic        side;
    logic        set;
    logic [31:0] price;
    logic [31:0] mag;
    logic        pos_p;
    logic        pos_n;
  } entry_t;

  typedef struct packed {
    logic [1:0]  ref_src;
    logic [31:0] cfg_ref;
    logic [31:0] gmin;
    logic [15:0] inc;
    logic [7:0]  bid_off;
    logic [7:0]  ask_off;
    logic [7:0]  max_skew;
    logic [30:0] pos_lim;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] bid;
    logic [31:0] ask;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: sv/iqp_front.sv
// ----------------------------------------------------------------------------
// iqp_front
// Classifies incoming beats and builds queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iqp_front import iqp_pkg::*; (
  input  logic [1:0]  opcode_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] level_quantity_i,
  input  logic [31:0] net_position_i,
  input  logic        kill_switch_i,
  output entry_t      entry_o,
  output logic        known_o
);

  always_comb begin
    entry_o.side  = side_i;
    entry_o.set   = level_quantity_i != 32'd0;
    entry_o.price = price_i;
    entry_o.mag   = net_position_i[31] ? (32'd0 - net_position_i) : net_position_i;
    entry_o.pos_n = net_position_i[31];
    entry_o.pos_p = !net_position_i[31] && (net_position_i != 32'd0);
    known_o       = 1'b1;
    unique case (opcode_i)
      OP_UPDATE: entry_o.kind = K_UPDATE;
      OP_TRADE:  entry_o.kind = K_TRADE;
      OP_DECIDE: entry_o.kind = kill_switch_i ? K_KILL : K_DECIDE;
      default: begin
        entry_o.kind = K_TRADE;
        known_o      = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/iqp_fifo.sv
// ----------------------------------------------------------------------------
// iqp_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iqp_fifo import iqp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     entry_i,
  input  logic       pop_i,
  output entry_t     head_o,
  output fifo_stat_t stat_o
);

  entry_t     mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = do_push ? !wp_q : wp_q;
    rp_d  = do_pop ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= entry_i;
    end
  end

endmodule

// File: sv/iqp_div.sv
// ----------------------------------------------------------------------------
// iqp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iqp_div import iqp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    qbit  = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      quo_q <= {quo_q[DIV_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: sv/iqp_back.sv
// ----------------------------------------------------------------------------
// iqp_back
// Book state and decision sequencer with a shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iqp_back import iqp_pkg::*; #(
  parameter int TICKS = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  entry_t  head_i,
  input  logic    head_valid_i,
  output logic    pop_o,
  input  cfg_t    cfg_i,
  input  logic    res_pop_i,
  output result_t res_o,
  output logic    res_full_o
);

  localparam int TB  = $clog2(TICKS);
  localparam int NCH = (TICKS + 7) / 8;
  localparam int NW  = NCH * 8;
  localparam int CB  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [TB-1:0] TOP = TB'(TICKS - 1);

  back_state_e st_q, st_d;
  entry_t      cur_q;
  logic [TICKS-1:0] bid_q, ask_q;
  logic        trade_seen_q;
  logic [31:0] last_trade_q;
  logic [CB-1:0] chunk_q;
  logic        bfound_q, afound_q;
  logic [TB-1:0] bbest_q, abest_q, center_q, bt_q, at_q;
  logic [32:0] bpx_q, apx_q;
  logic [33:0] ref_q;
  logic [39:0] prod_q, skew_q;
  logic        ok_q;
  logic [31:0] pbid_q, pask_q;
  result_t     res_q;
  logic        res_full_q;

  logic [15:0]      inc1;
  logic             div_start, div_done, emit;
  logic [DIV_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs;
  logic [NW-1:0]    bid_pad, ask_pad;
  logic [7:0]       bch, ach;
  logic [2:0]       bhi, alo;
  logic             bany, aany;
  logic [32:0]      lo, hi;
  logic [39:0]      c40, t40, cadj;
  logic [TB-1:0]    lb, la;
  logic             lok;
  logic [32:0]      bpr, apr;

  assign inc1    = (cfg_i.inc == 16'd0) ? 16'd1 : cfg_i.inc;
  assign bid_pad = NW'(bid_q);
  assign ask_pad = NW'(ask_q);
  assign bch     = bid_pad[{chunk_q, 3'b000} +: 8];
  assign ach     = ask_pad[{chunk_q, 3'b000} +: 8];

  always_comb begin
    bhi  = '0;
    bany = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (bch[i]) begin
        bhi  = 3'(i);
        bany = 1'b1;
      end
    end
    alo  = '0;
    aany = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (ach[i]) begin
        alo  = 3'(i);
        aany = 1'b1;
      end
    end
  end

  always_comb begin
    lo   = (bpx_q < apx_q) ? bpx_q : apx_q;
    hi   = (bpx_q < apx_q) ? apx_q : bpx_q;
    c40  = 40'(center_q);
    t40  = 40'(TOP) - c40;
    cadj = c40;
    if (cur_q.pos_p) begin
      cadj = (skew_q > c40) ? 40'd0 : c40 - skew_q;
    end else if (cur_q.pos_n) begin
      cadj = (skew_q > t40) ? 40'(TOP) : c40 + skew_q;
    end
    lb  = bt_q;
    la  = at_q;
    lok = 1'b1;
    if (afound_q && (bt_q >= abest_q)) begin
      if (abest_q == '0) lok = 1'b0;
      lb = abest_q - 1'b1;
    end
    if (bfound_q && (at_q <= bbest_q)) begin
      if (bbest_q == TOP) lok = 1'b0;
      la = bbest_q + 1'b1;
    end
    if (lb >= la) lok = 1'b0;
    bpr = 33'(cfg_i.gmin) + 33'(bt_q * inc1);
    apr = 33'(cfg_i.gmin) + 33'(at_q * inc1);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (head_valid_i) st_d = S_DISP;
      S_DISP: begin
        unique case (cur_q.kind)
          K_UPDATE: st_d = (cur_q.price < cfg_i.gmin) ? S_IDLE : S_UW;
          K_TRADE:  st_d = S_IDLE;
          K_DECIDE: st_d = S_SCAN;
          K_KILL:   st_d = S_EMIT;
          default:  st_d = S_IDLE;
        endcase
      end
      S_UW:   if (div_done) st_d = S_IDLE;
      S_SCAN: if (chunk_q == CB'(NCH - 1)) st_d = S_REF;
      S_REF: begin
        priority if (cfg_i.ref_src == REF_CONFIG) st_d = S_CDIV;
        else if (cfg_i.ref_src == REF_TRADE) st_d = trade_seen_q ? S_CDIV : S_EMIT;
        else st_d = (bfound_q && afound_q) ? S_MID : S_EMIT;
      end
      S_MID:  st_d = S_CDIV;
      S_CDIV: st_d = (ref_q < 34'(cfg_i.gmin)) ? S_SKEW : S_CW;
      S_CW:   if (div_done) st_d = S_SKEW;
      S_SKEW: begin
        priority if (cur_q.mag == 32'd0) st_d = S_ADJ;
        else if ((cur_q.mag == {1'b0, cfg_i.pos_lim}) || (cfg_i.pos_lim == 31'd0))
          st_d = S_ADJ;
        else st_d = S_SDIV;
      end
      S_SDIV: st_d = S_SW;
      S_SW:   if (div_done) st_d = S_ADJ;
      S_ADJ:  st_d = S_OFF;
      S_OFF:  st_d = S_LIM;
      S_LIM:  st_d = S_PRC;
      S_PRC:  st_d = S_EMIT;
      S_EMIT: if (!res_full_q || res_pop_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DVS_W'(inc1);
    emit      = 1'b0;
    unique case (st_q)
      S_IDLE: pop_o = head_valid_i;
      S_DISP: begin
        div_start = (cur_q.kind == K_UPDATE) && (cur_q.price >= cfg_i.gmin);
        div_dvd   = DIV_W'(cur_q.price - cfg_i.gmin);
      end
      S_CDIV: begin
        div_start = ref_q >= 34'(cfg_i.gmin);
        div_dvd   = DIV_W'(ref_q - 34'(cfg_i.gmin));
      end
      S_SDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dvs   = DVS_W'(cfg_i.pos_lim);
      end
      S_EMIT: emit = !res_full_q || res_pop_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      bid_q        <= '0;
      ask_q        <= '0;
      trade_seen_q <= 1'b0;
      last_trade_q <= '0;
      res_full_q   <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_DISP && cur_q.kind == K_TRADE) begin
        trade_seen_q <= 1'b1;
        last_trade_q <= cur_q.price;
      end
      if (st_q == S_UW && div_done && div_quot < DIV_W'(TICKS)) begin
        if (cur_q.side) ask_q[div_quot[TB-1:0]] <= cur_q.set;
        else bid_q[div_quot[TB-1:0]] <= cur_q.set;
      end
      if (emit) res_full_q <= 1'b1;
      else if (res_pop_i) res_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: if (head_valid_i) cur_q <= head_i;
      S_DISP: begin
        chunk_q  <= '0;
        bfound_q <= 1'b0;
        afound_q <= 1'b0;
        ok_q     <= 1'b0;
      end
      S_SCAN: begin
        chunk_q <= chunk_q + 1'b1;
        if (bany) begin
          bfound_q <= 1'b1;
          bbest_q  <= TB'({chunk_q, bhi});
        end
        if (aany && !afound_q) begin
          afound_q <= 1'b1;
          abest_q  <= TB'({chunk_q, alo});
        end
      end
      S_REF: begin
        ref_q <= (cfg_i.ref_src == REF_CONFIG) ? 34'(cfg_i.cfg_ref) : 34'(last_trade_q);
        bpx_q <= 33'(cfg_i.gmin) + 33'(bbest_q * inc1);
        apx_q <= 33'(cfg_i.gmin) + 33'(abest_q * inc1);
      end
      S_MID:  ref_q <= 34'(lo) + 34'((hi - lo) >> 1);
      S_CDIV: center_q <= '0;
      S_CW: if (div_done) begin
        center_q <= (div_quot > DIV_W'(TOP)) ? TOP : div_quot[TB-1:0];
      end
      S_SKEW: begin
        skew_q <= (cur_q.mag == 32'd0) ? 40'd0 : 40'(cfg_i.max_skew);
        prod_q <= 40'(cur_q.mag * cfg_i.max_skew);
      end
      S_SW: if (div_done) skew_q <= div_quot;
      S_ADJ: center_q <= cadj[TB-1:0];
      S_OFF: begin
        bt_q <= (13'(cfg_i.bid_off) > 13'(center_q)) ? '0 : center_q - TB'(cfg_i.bid_off);
        at_q <= (13'(cfg_i.ask_off) > 13'(TOP - center_q)) ? TOP
                : TB'(13'(center_q) + 13'(cfg_i.ask_off));
      end
      S_LIM: begin
        bt_q <= lb;
        at_q <= la;
        ok_q <= lok;
      end
      S_PRC: begin
        ok_q   <= ok_q && !bpr[32] && !apr[32];
        pbid_q <= bpr[31:0];
        pask_q <= apr[31:0];
      end
      S_EMIT: if (emit) begin
        res_q.valid <= ok_q;
        res_q.bid   <= ok_q ? pbid_q : 32'd0;
        res_q.ask   <= ok_q ? pask_q : 32'd0;
      end
      default: ;
    endcase
  end

  iqp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign res_o      = res_q;
  assign res_full_o = res_full_q;

endmodule

// File: sv/inventory_skewed_quote_pricer_core.sv
// ----------------------------------------------------------------------------
// inventory_skewed_quote_pricer_core: one item at a time, set by back sequencer.
// Per item: trade records its price, update does at most one 40-step divide, kill goes straight to emit.
// Decision: book scan over ceil(TICKS/8) chunks, then at most two 40-step divides.
// A result waits in its output register while the next items are accepted.
// Reset clears book, last trade and configuration registers at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inventory_skewed_quote_pricer_core_defines.svh"
module inventory_skewed_quote_pricer_core import iqp_pkg::*; #(
  parameter int TICKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] level_quantity_i,
  input  logic signed [31:0] net_position_i,
  input  logic        kill_switch_i,
  output logic        empty,
  input  logic        pop,
  output logic        quotes_valid_o,
  output logic [31:0] bid_price_o,
  output logic [31:0] ask_price_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  entry_t     fentry, head;
  logic       known, fifo_pop, res_full;
  fifo_stat_t fstat;
  result_t    res;
  logic       wr;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_src  <= 2'd0;
      cfg_q.cfg_ref  <= 32'd0;
      cfg_q.gmin     <= 32'd0;
      cfg_q.inc      <= 16'd1;
      cfg_q.bid_off  <= 8'd1;
      cfg_q.ask_off  <= 8'd1;
      cfg_q.max_skew <= 8'd0;
      cfg_q.pos_lim  <= 31'd1;
    end else if (wr) begin
      unique case (ridx)
        REG_REF_SRC:  cfg_q.ref_src  <= pwdata[1:0];
        REG_CFG_REF:  cfg_q.cfg_ref  <= pwdata;
        REG_GRID_MIN: cfg_q.gmin     <= pwdata;
        REG_GRID_INC: cfg_q.inc      <= pwdata[15:0];
        REG_BID_OFF:  cfg_q.bid_off  <= pwdata[7:0];
        REG_ASK_OFF:  cfg_q.ask_off  <= pwdata[7:0];
        REG_MAX_SKEW: cfg_q.max_skew <= pwdata[7:0];
        REG_POS_LIM:  cfg_q.pos_lim  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_REF_SRC:  prdata = 32'(cfg_q.ref_src);
      REG_CFG_REF:  prdata = cfg_q.cfg_ref;
      REG_GRID_MIN: prdata = cfg_q.gmin;
      REG_GRID_INC: prdata = 32'(cfg_q.inc);
      REG_BID_OFF:  prdata = 32'(cfg_q.bid_off);
      REG_ASK_OFF:  prdata = 32'(cfg_q.ask_off);
      REG_MAX_SKEW: prdata = 32'(cfg_q.max_skew);
      REG_POS_LIM:  prdata = 32'(cfg_q.pos_lim);
      default:      prdata = 32'd0;
    endcase
  end

  iqp_front u_front (
    .opcode_i        (opcode_i),
    .side_i          (side_i),
    .price_i         (price_i),
    .level_quantity_i(level_quantity_i),
    .net_position_i  (net_position_i),
    .kill_switch_i   (kill_switch_i),
    .entry_o         (fentry),
    .known_o         (known)
  );

  iqp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && known),
    .entry_i(fentry),
    .pop_i  (fifo_pop),
    .head_o (head),
    .stat_o (fstat)
  );

  iqp_back #(.TICKS(TICKS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(!fstat.empty),
    .pop_o       (fifo_pop),
    .cfg_i       (cfg_q),
    .res_pop_i   (pop),
    .res_o       (res),
    .res_full_o  (res_full)
  );

  assign full           = fstat.full;
  assign empty          = !res_full;
  assign quotes_valid_o = res.valid;
  assign bid_price_o    = res.bid;
  assign ask_price_o    = res.ask;

  `IQP_ASSERT_IMP(a_bid_below_ask, quotes_valid_o && !empty, bid_price_o < ask_price_o, "crossed")
  `IQP_ASSERT_IMP(a_noquote_zero, !quotes_valid_o && !empty, (bid_price_o | ask_price_o) == '0, "stale")
  `IQP_ASSERT(a_fifo_stat, !(fstat.full && fstat.empty), "queue full and empty")

endmodule
